// ===== src/ins_srt_pkg.sv =====
// ----------------------------------------------------------------------------
// ins_srt_pkg
// Shared widths, sizes and link types of the insertion sorter cell chain.
// ----------------------------------------------------------------------------
package ins_srt_pkg;

    localparam int MAX_ELEMS = 32;
    localparam int DATA_W    = 32;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;   // place the key, push larger entries one cell up
        logic drain;    // shift every entry one cell down toward the output
    } cell_ctrl_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic                     valid;
        logic                     le;     // holds a value not greater than the key
        logic signed [DATA_W-1:0] value;
    } cell_link_t;

endpackage

// ===== src/insertion_sorter_top.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter_top
// Stable ascending insertion sorter built as a chain of compare-and-shift
// cells, with a registered output stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_axis: s_tdata is the signed 32-bit value, s_tlast
//   marks the last value of a set. While a set is loading, one word is taken
//   every cycle; each cell compares its entry against the new value in
//   parallel, so the whole chain updates on every insertion.
//   A word accepted with s_tlast starts the unload: s_tready drops, and the
//   chain shifts toward cell 0 one entry per cycle into the output register
//   whenever that register is empty or m_tready is high. The last input word
//   sets drain_reg; the first result then moves into the output register.
//   m_tlast marks the final result, m_tuser is set on every result of a set
//   that lost values to a full chain (capacity MAX_ELEMS). s_tready returns at
//   the edge that loads the final result, so the next set may start loading
//   while it waits. A stalled receiver (m_tready low) holds the output word
//   and freezes the chain; nothing is lost.
//   Reset (aresetn low, synchronous) empties the chain, clears the drop flag
//   and the output valid; s_tready is high right after reset.
// ----------------------------------------------------------------------------
module insertion_sorter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // final_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] sorted_value
    output logic        m_tlast,   // end_of_set
    output logic        m_tuser    // [0] overflow
);

    localparam int N = ins_srt_pkg::MAX_ELEMS;

    ins_srt_pkg::cell_ctrl_t ctrl;
    ins_srt_pkg::cell_link_t links [N];
    ins_srt_pkg::cell_link_t lower_bound;
    ins_srt_pkg::cell_link_t upper_bound;

    logic drain_reg,   drain_next;
    logic dropped_reg, dropped_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;
    logic m_last_reg,  m_last_next;
    logic m_user_reg,  m_user_next;

    logic accept;
    logic full;
    logic pop_ok;
    logic signed [ins_srt_pkg::DATA_W-1:0] key;

    assign key    = s_tdata;
    assign full   = links[N-1].valid;
    assign accept = s_tvalid && !drain_reg;
    assign pop_ok = !m_valid_reg || m_tready;

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = drain_reg && pop_ok;

    // Below cell 0: always valid and not greater than any key
    assign lower_bound.valid = 1'b1;
    assign lower_bound.le    = 1'b1;
    assign lower_bound.value = '0;
    // Above the top cell: empty
    assign upper_bound.valid = 1'b0;
    assign upper_bound.le    = 1'b0;
    assign upper_bound.value = '0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        ins_srt_pkg::cell_link_t lower_l;
        ins_srt_pkg::cell_link_t upper_l;
        if (i == 0) begin : g_first
            assign lower_l = lower_bound;
        end else begin : g_mid_lo
            assign lower_l = links[i-1];
        end
        if (i == N-1) begin : g_last
            assign upper_l = upper_bound;
        end else begin : g_mid_hi
            assign upper_l = links[i+1];
        end
        ins_srt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .key     (key),
            .lower   (lower_l),
            .upper   (upper_l),
            .link    (links[i])
        );
    end

    always_comb begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            if (full) begin
                dropped_next = 1'b1;
            end
            if (s_tlast) begin
                drain_next = 1'b1;
            end
        end

        if (ctrl.drain) begin
            m_valid_next = 1'b1;
            m_data_next  = links[0].value;
            m_last_next  = !links[1].valid;
            m_user_next  = dropped_reg;
            // Last entry leaving: reopen the input for the next set
            if (!links[1].valid) begin
                drain_next   = 1'b0;
                dropped_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = !drain_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== src/ins_srt_cell.sv =====
// ----------------------------------------------------------------------------
// ins_srt_cell
// One slot of the ordered chain: compares its entry against the broadcast
// key, and takes the key, the lower neighbor's entry or the upper one's.
// ----------------------------------------------------------------------------
module ins_srt_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ins_srt_pkg::cell_ctrl_t          ctrl,
    input  logic signed [ins_srt_pkg::DATA_W-1:0] key,
    input  ins_srt_pkg::cell_link_t          lower,
    input  ins_srt_pkg::cell_link_t          upper,
    output ins_srt_pkg::cell_link_t          link
);

    logic                                   valid_reg, valid_next;
    logic signed [ins_srt_pkg::DATA_W-1:0]  value_reg, value_next;
    logic                                   le;
    logic                                   shift_in;
    logic                                   put_key;

    assign le = valid_reg && (value_reg <= key);

    // Lower neighbor is greater than the key: its entry moves up into this cell
    assign shift_in = lower.valid && !lower.le;
    // First cell above all entries not greater than the key takes the key
    assign put_key  = !shift_in && !le && lower.valid;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (ctrl.drain) begin
            valid_next = upper.valid;
            value_next = upper.value;
        end else if (ctrl.insert) begin
            if (shift_in) begin
                valid_next = 1'b1;
                value_next = lower.value;
            end else if (put_key) begin
                valid_next = 1'b1;
                value_next = key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

    assign link.valid = valid_reg;
    assign link.le    = le;
    assign link.value = value_reg;

endmodule

// ===== bench/tb_insertion_sorter_top.sv =====
// ----------------------------------------------------------------------------
// tb_insertion_sorter_top
// Self-checking bench for the insertion sorter. Sets of signed values go in
// on s_axis; a behavioral sorter predicts each set's output words, which are
// checked in order on m_axis. Covers the value extremes, duplicates, a full
// chain, dropped words, and random sets under several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_insertion_sorter_top;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 12;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYC    = 40;

    typedef struct packed {
        logic [ins_srt_pkg::DATA_W-1:0] value;
        logic                           end_of_set;
        logic                           overflow;
    } sorted_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic        s_tlast  = 1'b0; // final_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [31:0] sorted_value
    logic        m_tlast;         // end_of_set
    logic        m_tuser;         // [0] overflow

    // sorter state mirror
    logic signed [ins_srt_pkg::DATA_W-1:0] chain_mirror[$];
    logic                                  set_dropped = 1'b0;
    sorted_word_t                          sorted_words[$];

    int error_count    = 0;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    insertion_sorter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    // Insert behind every stored value not greater than the key; emit on final.
    function automatic void predict_sort(input logic signed [ins_srt_pkg::DATA_W-1:0] key,
                                         input logic fin);
        int           pos;
        sorted_word_t w;
        if (chain_mirror.size() < ins_srt_pkg::MAX_ELEMS) begin
            pos = chain_mirror.size();
            while (pos > 0 && chain_mirror[pos-1] > key)
                pos--;
            chain_mirror.insert(pos, key);
        end else begin
            set_dropped = 1'b1;
        end
        if (fin) begin
            for (int k = 0; k < chain_mirror.size(); k++) begin
                w.value      = chain_mirror[k];
                w.end_of_set = (k == chain_mirror.size() - 1);
                w.overflow   = set_dropped;
                sorted_words.push_back(w);
            end
            chain_mirror.delete();
            set_dropped = 1'b0;
        end
    endfunction

    // Receiver: random backpressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Output checker.
    always @(posedge aclk) begin
        sorted_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (sorted_words.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, '0);
            end else begin
                w = sorted_words.pop_front();
                if (m_tdata !== w.value)
                    report_mismatch("sorted_value", m_tdata, w.value);
                if (m_tlast !== w.end_of_set)
                    report_mismatch("end_of_set", m_tlast, w.end_of_set);
                if (m_tuser !== w.overflow)
                    report_mismatch("overflow", m_tuser, w.overflow);
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_insertion_sorter_top: errors");
                $finish;
            end
        end
    end

    // Hold valid high across back-to-back words; drop it only while idling.
    task automatic send_word(input logic signed [ins_srt_pkg::DATA_W-1:0] v,
                             input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        predict_sort(v, fin);
    endtask

    task automatic sender_idle();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (sorted_words.size() != 0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            5, 6, 7: pick_value = 32'(int'($urandom_range(0, 16)) - 8);
            8:       pick_value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            9:       pick_value = $urandom_range(0, 1) ? 32'h7fff_fff0 + $urandom_range(0, 15)
                                                       : 32'h8000_0000 + $urandom_range(0, 15);
            default: pick_value = $urandom;
        endcase
    endfunction

    function automatic int pick_set_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            pick_set_size = $urandom_range(1, 8);
        else if (r < 95)
            pick_set_size = $urandom_range(9, 31);
        else
            pick_set_size = $urandom_range(32, 40);
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_word(pick_value(), i == n - 1);
    endtask

    task automatic test_directed();
        logic [31:0] extremes[7];
        logic [31:0] dups[6];
        extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
                     32'h1, 32'h8000_0001, 32'h7fff_fffe};
        dups     = '{32'd5, -32'sd3, 32'd5, 32'd5, -32'sd3, 32'd0};
        // single-word set
        send_word(32'h8000_0000, 1'b1);
        foreach (extremes[i])
            send_word(extremes[i], i == 6);
        foreach (dups[i])
            send_word(dups[i], i == 5);
        // descending input, worst case shifting
        for (int i = 4; i >= 1; i--)
            send_word(i, i == 1);
        send_word(32'h0, 1'b0);
        send_word(32'h0, 1'b1);
    endtask

    // Exactly full, then over capacity with the final word itself dropped.
    task automatic test_capacity();
        send_set(ins_srt_pkg::MAX_ELEMS);
        send_set(ins_srt_pkg::MAX_ELEMS + 3);
        send_set(ins_srt_pkg::MAX_ELEMS + 1);
    endtask

    task automatic test_drain_pause();
        for (int s = 0; s < 3; s++) begin
            send_set($urandom_range(1, 10));
            sender_idle();
            wait_drained();
        end
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int count);
        int sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < count) begin
            int n;
            n = pick_set_size();
            send_set(n);
            sent += n;
        end
    endtask

    initial begin
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_capacity();
        test_drain_pause();
        test_random(0, 0, 50);
        test_random(56, 0, 50);
        test_random(0, 56, 50);
        test_random(31, 31, 50);

        sender_idle();
        wait_drained();
        repeat (TAIL_CYC) @(posedge aclk);
        if (error_count == 0)
            $display("tb_insertion_sorter_top: clean");
        else
            $display("tb_insertion_sorter_top: errors");
        $finish;
    end

endmodule
